@@ rtl/reb_pkg.sv @@
// shared types and constants for the rotary encoder and button event core
package reb_pkg;

  localparam int TIME_BITS     = 32;
  localparam int DEBOUNCE_BITS = 8;
  localparam int LONG_BITS     = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS = 1'd1;

  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET   = 8'd20;
  localparam logic [LONG_BITS-1:0]     LONG_PRESS_RESET = 16'd1000;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_CW    = 3'd1,
    EV_CCW   = 3'd2,
    EV_CLICK = 3'd3,
    EV_PRESS = 3'd4
  } ev_code_t;

  typedef struct packed {
    logic                 clk_level;
    logic                 dt_level;
    logic                 switch_level;
    logic [TIME_BITS-1:0] time_now;
    logic                 take_event;
  } reb_in_t;

  typedef struct packed {
    ev_code_t event_code;
    logic     event_ready;
  } reb_out_t;

  // decoder state carried from poll to poll
  typedef struct packed {
    logic                 prev_clk;
    logic                 prev_switch;
    logic [TIME_BITS-1:0] debounce_stamp;
    logic [TIME_BITS-1:0] press_stamp;
    logic                 long_sent;
    ev_code_t             pending;
  } reb_state_t;

  typedef struct packed {
    logic [DEBOUNCE_BITS-1:0] debounce_time;
    logic [LONG_BITS-1:0]     long_press_time;
  } reb_cfg_t;

endpackage

@@ rtl/reb_eval.sv @@
// next-state and result logic for one encoder and switch poll
module reb_eval import reb_pkg::*; (
  input  reb_state_t state,
  input  reb_cfg_t   cfg,
  input  reb_in_t    poll,
  output reb_state_t state_nxt,
  output reb_out_t   result
);

  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] since_press;
  logic                 in_window;
  reb_state_t           mid;

  assign since_change = poll.time_now - state.debounce_stamp;
  assign in_window    = since_change < TIME_BITS'(cfg.debounce_time);

  always_comb begin
    mid = state;
    // rotary: falling clk edge picks direction from dt
    if (poll.clk_level != state.prev_clk) begin
      mid.prev_clk = poll.clk_level;
      if (!poll.clk_level) begin
        mid.pending = poll.dt_level ? EV_CW : EV_CCW;
      end
    end
    if (poll.switch_level != state.prev_switch && !in_window) begin
      mid.debounce_stamp = poll.time_now;
      mid.prev_switch    = poll.switch_level;
      if (!poll.switch_level) begin
        mid.press_stamp = poll.time_now;
        mid.long_sent   = 1'b0;
      end else if (!state.long_sent) begin
        mid.pending = EV_CLICK;
      end
    end
  end

  assign since_press = poll.time_now - mid.press_stamp;

  always_comb begin
    state_nxt = mid;
    // a bounce inside the window also skips the long-press check
    if (!(poll.switch_level != state.prev_switch && in_window) &&
        !poll.switch_level && !mid.long_sent &&
        since_press >= TIME_BITS'(cfg.long_press_time)) begin
      state_nxt.long_sent = 1'b1;
      state_nxt.pending   = EV_PRESS;
    end
    result.event_code  = state_nxt.pending;
    result.event_ready = (state_nxt.pending != EV_NONE);
    if (poll.take_event) begin
      state_nxt.pending = EV_NONE;
    end
  end

endmodule

@@ rtl/rotary_encoder_button_events_core.sv @@
// Rotary encoder and debounced push switch event core. Each input transaction is one
// poll of the CLK, DT and switch pins with a millisecond timestamp; each poll yields
// exactly one output transaction showing the single pending-event slot (0 none,
// 1 clockwise, 2 counter-clockwise, 3 click, 4 long press), cleared afterwards when
// take_event is set. One poll is accepted per clock cycle: the whole state update is
// one combinational pass into the state and output registers, so a result appears in
// the cycle after its poll, and the input stalls only while the output register holds
// a result that has not been taken. The user must write debounce_time (index 0) and
// long_press_time (index 1) via the cfg port only while idle; this is not enforced.
module rotary_encoder_button_events_core import reb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  reb_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output reb_out_t                 out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  reb_state_t state_r;
  reb_state_t state_nxt;
  reb_cfg_t   cfg_r;
  reb_out_t   out_data_r;
  reb_out_t   result;
  logic       out_valid_r;
  logic       in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  reb_eval u_eval (
    .state     (state_r),
    .cfg       (cfg_r),
    .poll      (in_data),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= DEBOUNCE_RESET;
      cfg_r.long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   cfg_r.debounce_time   <= cfg_wdata[DEBOUNCE_BITS-1:0];
        REG_LONG_PRESS: cfg_r.long_press_time <= cfg_wdata[LONG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.prev_clk       <= 1'b1;
      state_r.prev_switch    <= 1'b1;
      state_r.debounce_stamp <= '0;
      state_r.press_stamp    <= '0;
      state_r.long_sent      <= 1'b0;
      state_r.pending        <= EV_NONE;
      out_valid_r            <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= result;
    end
  end

`ifndef SYNTHESIS
  a_ready_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.event_ready == (out_data_r.event_code != EV_NONE)))
    else $error("event_ready disagrees with event_code");

  a_long_reported: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r.long_sent) |-> (out_data_r.event_code == EV_PRESS))
    else $error("long press latched without a press event");

  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.take_event) |=> (state_r.pending == EV_NONE))
    else $error("take_event did not clear the pending slot");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(state_r))
    else $error("state changed without a poll");
`endif

endmodule

@@ dv/tb_rotary_encoder_button_events_core.sv @@
// testbench for the rotary encoder and push switch event core
module tb_rotary_encoder_button_events_core;
  import reb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  reb_in_t                  in_data;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  reb_out_t                 out_data;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  rotary_encoder_button_events_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // decoder state and register copies tracked by the testbench
  logic                     seen_clk;
  logic                     seen_sw;
  logic [TIME_BITS-1:0]     db_mark;
  logic [TIME_BITS-1:0]     press_mark;
  logic                     long_done;
  ev_code_t                 slot;
  logic [DEBOUNCE_BITS-1:0] db_ms;
  logic [LONG_BITS-1:0]     long_ms;

  reb_out_t events_due[$];
  int       fail_count = 0;

  // pin levels and clock of the poll stream
  logic                 cur_clk = 1'b1;
  logic                 cur_dt  = 1'b1;
  logic                 cur_sw  = 1'b1;
  logic [TIME_BITS-1:0] ms_now  = '0;

  int burst_left = 0;
  int hold_off_reqs = 0;

  function automatic reb_out_t decode_poll(reb_in_t p);
    logic                 check_long;
    logic [TIME_BITS-1:0] since_db;
    logic [TIME_BITS-1:0] since_press;
    reb_out_t             r;
    check_long = 1'b1;
    if (p.clk_level != seen_clk) begin
      if (!p.clk_level) slot = (p.dt_level != p.clk_level) ? EV_CW : EV_CCW;
      seen_clk = p.clk_level;
    end
    since_db = p.time_now - db_mark;
    if (p.switch_level != seen_sw) begin
      if (since_db < {{(TIME_BITS-DEBOUNCE_BITS){1'b0}}, db_ms}) begin
        // bounce: the rest of the switch handling is skipped
        check_long = 1'b0;
      end else begin
        db_mark = p.time_now;
        seen_sw = p.switch_level;
        if (!p.switch_level) begin
          press_mark = p.time_now;
          long_done  = 1'b0;
        end else if (!long_done) begin
          slot = EV_CLICK;
        end
      end
    end
    since_press = p.time_now - press_mark;
    if (check_long && !p.switch_level && !long_done &&
        since_press >= {{(TIME_BITS-LONG_BITS){1'b0}}, long_ms}) begin
      long_done = 1'b1;
      slot      = EV_PRESS;
    end
    r.event_code  = slot;
    r.event_ready = (slot != EV_NONE);
    if (p.take_event) slot = EV_NONE;
    return r;
  endfunction

  task automatic send_poll(input reb_in_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    events_due.push_back(decode_poll(p));
  endtask

  task automatic step(input logic c, input logic d, input logic s,
                      input int unsigned adv, input logic tk);
    reb_in_t p;
    cur_clk = c;
    cur_dt  = d;
    cur_sw  = s;
    ms_now  = ms_now + adv;
    p.clk_level    = c;
    p.dt_level     = d;
    p.switch_level = s;
    p.time_now     = ms_now;
    p.take_event   = tk;
    send_poll(p);
  endtask

  // stop offering polls and wait for every result to come back
  task automatic drain(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (events_due.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    if (events_due.size() != 0) begin
      $error("%0d expected transactions never arrived", events_due.size());
      fail_count++;
      events_due.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE:   db_ms   = val[DEBOUNCE_BITS-1:0];
      REG_LONG_PRESS: long_ms = val[LONG_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic random_polls(input int n);
    int          kind;
    int unsigned adv;
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // one quadrature step in either direction
        if ($urandom_range(0, 1)) cur_clk = ~cur_clk;
        else cur_dt = ~cur_dt;
      end else if (kind < 62) begin
        cur_sw = ~cur_sw;
      end else if (kind >= 90) begin
        cur_clk = 1'($urandom_range(0, 1));
        cur_dt  = 1'($urandom_range(0, 1));
        cur_sw  = 1'($urandom_range(0, 1));
      end
      kind = $urandom_range(0, 99);
      if (kind < 60)      adv = $urandom_range(0, 8);
      else if (kind < 85) adv = $urandom_range(0, 2 * db_ms + 2);
      else if (kind < 97) adv = $urandom_range(0, long_ms + 5);
      else                adv = $urandom;
      step(cur_clk, cur_dt, cur_sw, adv, $urandom_range(0, 9) < 3);
    end
  endtask

  task automatic test_directed_basics();
    step(1, 1, 1, 0, 0);
    step(0, 1, 1, 5, 0);    // clockwise
    step(0, 1, 1, 1, 1);
    step(1, 0, 1, 1, 0);    // rising edge, nothing
    step(0, 0, 1, 1, 0);    // counter-clockwise
    step(1, 0, 1, 1, 1);
    step(1, 1, 0, 30, 0);   // press
    step(1, 1, 1, 5, 0);    // bounce inside the window
    step(1, 1, 0, 1, 0);
    step(1, 1, 1, 25, 0);   // click
    step(1, 1, 1, 1, 1);
    step(1, 1, 0, 40, 0);
    step(1, 1, 0, 999, 0);
    step(1, 1, 0, 1, 0);    // long press right at the limit
    step(1, 1, 0, 500, 1);
    step(1, 1, 1, 30, 0);   // release after long press, no click
    step(0, 1, 1, 1, 0);    // clockwise then overwritten by a click below
    step(0, 1, 0, 30, 0);
    step(0, 1, 1, 30, 0);
    // timestamp extremes and wrap
    ms_now = 32'hFFFF_FFF0;
    step(0, 1, 0, 0, 1);
    step(0, 1, 0, 15, 0);   // 0xffffffff
    step(0, 1, 1, 1, 0);    // wraps to zero
    step(1, 1, 1, 32'h7FFF_FFFF, 1);
    step(0, 0, 1, 32'h8000_0000, 1);
    drain(20000);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_DEBOUNCE, 16'hFF00);   // upper bits are dropped, so zero
    write_reg(REG_LONG_PRESS, 16'h0000);
    step(1, 0, 0, 1, 0);    // long press on the same poll as the press
    step(1, 0, 1, 0, 0);    // zero window accepts the release at once
    step(1, 0, 0, 0, 1);
    step(0, 1, 1, 0, 1);
    drain(20000);
    write_reg(REG_DEBOUNCE, 16'h00FF);
    write_reg(REG_LONG_PRESS, 16'hFFFF);
    step(0, 1, 0, 300, 0);
    step(0, 1, 0, 65534, 0);
    step(0, 1, 0, 1, 0);    // long press
    step(0, 1, 1, 10, 1);   // release after the long press, no click
    step(0, 1, 1, 300, 0);
    drain(20000);
  endtask

  task automatic test_random_config_phases();
    int k;
    for (k = 0; k < 6; k++) begin
      case (k)
        0: begin write_reg(REG_DEBOUNCE, 16'd20); write_reg(REG_LONG_PRESS, 16'd40); end
        1: begin write_reg(REG_DEBOUNCE, 16'd0);  write_reg(REG_LONG_PRESS, 16'd0); end
        2: begin write_reg(REG_DEBOUNCE, 16'hFF); write_reg(REG_LONG_PRESS, 16'hFFFF); end
        3: begin write_reg(REG_DEBOUNCE, 16'd1);  write_reg(REG_LONG_PRESS, 16'd1); end
        default: begin
          write_reg(REG_DEBOUNCE, CFG_DATA_BITS'($urandom));
          write_reg(REG_LONG_PRESS, CFG_DATA_BITS'($urandom_range(1, 600)));
        end
      endcase
      random_polls(300);
      drain(20000);
    end
  endtask

  task automatic test_receiver_holdoff();
    hold_off_reqs++;
    random_polls(40);
    drain(20000);
  endtask

  task automatic test_timestamp_wrap();
    write_reg(REG_DEBOUNCE, 16'd5);
    write_reg(REG_LONG_PRESS, 16'd30);
    ms_now = 32'hFFFF_FF80;
    random_polls(100);
    drain(1000);
  endtask

  // receiver: changing ready patterns plus one long hold-off on request
  int rx_mode = 0;
  int rx_left = 0;
  int rx_phase = 0;
  int hold_cnt = 0;
  int hold_off_served = 0;
  always @(posedge clk) begin
    rx_phase++;
    if (hold_off_served < hold_off_reqs) begin
      hold_off_served++;
      hold_cnt = 250;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 300);
      end
      rx_left--;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_phase % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    reb_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        $error("result transaction with none expected: event_code %0d",
               out_data.event_code);
        fail_count++;
      end else begin
        want = events_due.pop_front();
        if (out_data.event_code !== want.event_code) begin
          $error("event_code: expected %0d, actual %0d", want.event_code,
                 out_data.event_code);
          fail_count++;
        end
        if (out_data.event_ready !== want.event_ready) begin
          $error("event_ready: expected %0d, actual %0d", want.event_ready,
                 out_data.event_ready);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    seen_clk   = 1'b1;
    seen_sw    = 1'b1;
    db_mark    = '0;
    press_mark = '0;
    long_done  = 1'b0;
    slot       = EV_NONE;
    db_ms      = DEBOUNCE_RESET;
    long_ms    = LONG_PRESS_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_basics();
    test_register_extremes();
    test_random_config_phases();
    test_receiver_holdoff();
    test_timestamp_wrap();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/reb_pkg.sv
rtl/reb_eval.sv
rtl/rotary_encoder_button_events_core.sv
dv/tb_rotary_encoder_button_events_core.sv
